// ===== src/bcmp_pkg.sv =====
// Shared types and constants for the binomial coefficient mod prime block.
// Depends on nothing.
`default_nettype none
package bcmp_pkg;
    localparam logic [29:0] PRIME = 30'd998244353;
    localparam int          VW    = 30;
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME));

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOTRDY = 2'd2;

    localparam logic [3:0] S_NONE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_RDINV  = 4'd2;
    localparam logic [3:0] S_MULINV = 4'd3;
    localparam logic [3:0] S_WRINV  = 4'd4;
    localparam logic [3:0] S_MULFAC = 4'd5;
    localparam logic [3:0] S_WRFAC  = 4'd6;
    localparam logic [3:0] S_MULFI  = 4'd7;
    localparam logic [3:0] S_WRFI   = 4'd8;
    localparam logic [3:0] S_WRONE  = 4'd9;
    localparam logic [3:0] S_QRD    = 4'd10;
    localparam logic [3:0] S_QMUL1  = 4'd11;
    localparam logic [3:0] S_QMUL2  = 4'd12;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
    } t_status;
endpackage
`default_nettype wire

// ===== src/bcmp_mulmod.sv =====
// Multicycle modular multiplier: one 30x30 product, then a Barrett reduction whose steps are registered in turn.
// Depends on bcmp_pkg.
`default_nettype none
module bcmp_mulmod
    import bcmp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VW-1:0] i_a,
    input  wire logic [VW-1:0] i_b,
    output logic               o_busy,
    output logic [VW-1:0]      o_res
);
    logic [59:0]   r_prod;
    logic [30:0]   r_q;
    logic [31:0]   r_qp;
    logic [31:0]   r_rem;
    logic [VW-1:0] r_res;
    logic [2:0]    r_cnt;
    logic          r_busy;
    logic [61:0]   n_qfull;
    logic [31:0]   n_red1;
    logic [31:0]   n_red2;

    always_comb begin
        n_qfull = {31'd0, r_prod[59:29]} * {31'd0, BARRETT_MU};
        n_red1  = (r_rem >= 32'(PRIME)) ? r_rem - 32'(PRIME) : r_rem;
        n_red2  = (n_red1 >= 32'(PRIME)) ? n_red1 - 32'(PRIME) : n_red1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_prod <= 60'(i_a) * 60'(i_b);
            r_cnt  <= 3'd4;
        end else if (r_busy) begin
            case (r_cnt)
                3'd4:    r_q   <= n_qfull[61:31];
                3'd3:    r_qp  <= 32'(r_q) * 32'(PRIME);
                3'd2:    r_rem <= r_prod[31:0] - r_qp;
                3'd1: begin
                    r_res  <= n_red2[VW-1:0];
                    r_busy <= 1'b0;
                end
                default: r_busy <= 1'b0;
            endcase
            r_cnt <= r_cnt - 3'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;
endmodule
`default_nettype wire

// ===== src/bcmp_divider.sv =====
// Restoring divider of the prime by a small index: one quotient bit per cycle.
// Depends on bcmp_pkg.
`default_nettype none
module bcmp_divider
    import bcmp_pkg::*;
#(
    parameter int IW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [IW-1:0] i_den,
    output logic               o_busy,
    output logic [VW-1:0]      o_quo,
    output logic [IW-1:0]      o_rem
);
    logic [VW-1:0] r_num;
    logic [IW:0]   r_rem;
    logic [IW-1:0] r_den;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic [IW:0]   n_shift;

    assign n_shift = {r_rem[IW-1:0], r_num[VW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_num  <= PRIME;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= 5'(VW);
        end else if (r_busy) begin
            if (n_shift >= {1'b0, r_den}) begin
                r_rem <= n_shift - {1'b0, r_den};
                r_num <= {r_num[VW-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_num <= {r_num[VW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
    assign o_rem  = r_rem[IW-1:0];
endmodule
`default_nettype wire

// ===== src/bcmp_datapath.sv =====
// Datapath: the three table memories, the shared multiplier, the divider, operand registers.
// Depends on bcmp_pkg, bcmp_mulmod and bcmp_divider.
`default_nettype none
module bcmp_datapath
    import bcmp_pkg::*;
#(
    parameter int TABLE_SIZE = 4096,
    parameter int IW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [3:0]    i_step,
    input  wire logic          i_load,
    input  wire logic [IW-1:0] i_n,
    input  wire logic [IW-1:0] i_k,
    input  wire logic [IW-1:0] i_idx,
    output t_status            o_status,
    output logic [VW-1:0]      o_mul
);
    logic [VW-1:0] r_fac [TABLE_SIZE];
    logic [VW-1:0] r_inv [TABLE_SIZE];
    logic [VW-1:0] r_fi  [TABLE_SIZE];
    logic [VW-1:0] r_fac_rd, r_inv_rd, r_fi_rd, r_fi_rd2;
    logic [VW-1:0] r_prev_fac, r_prev_fi, r_new_inv, r_q;
    logic [IW-1:0] div_rem;
    logic [VW-1:0] div_quo;
    logic          div_busy, mul_busy, mul_start;
    logic [VW-1:0] mul_a, mul_b, mul_res;

    bcmp_divider #(.IW(IW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_step == S_DIV),
        .i_den(i_idx), .o_busy(div_busy), .o_quo(div_quo), .o_rem(div_rem)
    );

    always_comb begin
        mul_start = 1'b1;
        mul_a = '0;
        mul_b = '0;
        case (i_step)
            S_MULINV: begin mul_a = r_inv_rd;   mul_b = r_q; end
            S_MULFAC: begin mul_a = r_prev_fac; mul_b = VW'(i_idx); end
            S_MULFI:  begin mul_a = r_prev_fi;  mul_b = r_new_inv; end
            S_QMUL1:  begin mul_a = r_fi_rd;    mul_b = r_fi_rd2; end
            S_QMUL2:  begin mul_a = r_fac_rd;   mul_b = mul_res; end
            default:  mul_start = 1'b0;
        endcase
    end

    bcmp_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_busy(mul_busy), .o_res(mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prev_fac <= VW'(1);
            r_prev_fi  <= VW'(1);
        end
        case (i_step)
            S_RDINV: begin
                r_q      <= div_quo;
                r_inv_rd <= r_inv[div_rem];
            end
            S_WRINV: begin
                r_new_inv     <= PRIME - mul_res;
                r_inv[i_idx]  <= PRIME - mul_res;
            end
            S_WRFAC: begin
                r_prev_fac   <= mul_res;
                r_fac[i_idx] <= mul_res;
            end
            S_WRFI: begin
                r_prev_fi   <= mul_res;
                r_fi[i_idx] <= mul_res;
            end
            S_WRONE: begin
                r_fac[i_idx] <= VW'(1);
                r_fi[i_idx]  <= VW'(1);
                r_inv[i_idx] <= i_idx[0] ? VW'(1) : VW'(0);
            end
            S_QRD: begin
                r_fac_rd <= r_fac[i_n];
                r_fi_rd  <= r_fi[i_k];
                r_fi_rd2 <= r_fi[i_n - i_k];
            end
            default: ;
        endcase
    end

    assign o_status.mul_busy = mul_busy;
    assign o_status.div_busy = div_busy;
    assign o_mul = mul_res;
endmodule
`default_nettype wire

// ===== src/bcmp_ctrl.sv =====
// Controller state machine: sequences table build and queries over the datapath.
// Depends on bcmp_pkg.
`default_nettype none
module bcmp_ctrl
    import bcmp_pkg::*;
#(
    parameter int TABLE_SIZE = 4096,
    parameter int IW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic          i_action,
    input  wire logic [12:0]   i_n,
    input  wire logic [12:0]   i_k,
    input  t_status            i_status,
    input  wire logic [VW-1:0] i_mul,
    output logic [3:0]         o_step,
    output logic               o_load,
    output logic [IW-1:0]      o_n,
    output logic [IW-1:0]      o_k,
    output logic [IW-1:0]      o_idx,
    output logic               o_busy,
    output logic               o_done,
    output logic [VW-1:0]      o_value,
    output logic [1:0]         o_stat
);
    typedef enum logic [4:0] {
        IDLE, B_ONE, B_DIV, B_DWAIT, B_RDINV, B_MINV, B_WINV, B_MFAC, B_WFAC,
        B_MFI, B_WFI, Q_RD, Q_M1, Q_W1, Q_M2, Q_W2
    } t_state;

    t_state        r_state;
    logic [IW:0]   r_i;
    logic [IW-1:0] r_n, r_k;
    logic          r_ready, r_done;
    logic [VW-1:0] r_value;
    logic [1:0]    r_stat;
    logic signed [12:0] sn, sk;

    assign sn = i_n;
    assign sk = i_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                IDLE: if (i_go) begin
                    r_value <= '0;
                    r_stat  <= ST_OK;
                    if (!i_action) begin
                        r_i     <= '0;
                        r_state <= B_ONE;
                    end else if (!r_ready) begin
                        r_stat <= ST_NOTRDY;
                        r_done <= 1'b1;
                    end else if (sn < sk || sn < 0 || sk < 0) begin
                        r_done <= 1'b1;
                    end else if (32'(sn) >= TABLE_SIZE) begin
                        r_stat <= ST_RANGE;
                        r_done <= 1'b1;
                    end else begin
                        r_n     <= IW'(i_n);
                        r_k     <= IW'(i_k);
                        r_state <= Q_RD;
                    end
                end
                B_ONE: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i == (IW+1)'(1)) ?
                        ((TABLE_SIZE > 2) ? B_DIV : IDLE) : B_ONE;
                    if (r_i == (IW+1)'(1) && TABLE_SIZE <= 2) begin
                        r_ready <= 1'b1;
                        r_done  <= 1'b1;
                    end
                end
                B_DIV:   r_state <= B_DWAIT;
                B_DWAIT: if (!i_status.div_busy) r_state <= B_RDINV;
                B_RDINV: r_state <= B_MINV;
                B_MINV:  r_state <= B_WINV;
                B_WINV:  if (!i_status.mul_busy) r_state <= B_MFAC;
                B_MFAC:  r_state <= B_WFAC;
                B_WFAC:  if (!i_status.mul_busy) r_state <= B_MFI;
                B_MFI:   r_state <= B_WFI;
                B_WFI:   if (!i_status.mul_busy) begin
                    if (r_i == (IW+1)'(TABLE_SIZE - 1)) begin
                        r_ready <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= B_DIV;
                    end
                end
                Q_RD: r_state <= Q_M1;
                Q_M1: r_state <= Q_W1;
                Q_W1: if (!i_status.mul_busy) r_state <= Q_M2;
                Q_M2: r_state <= Q_W2;
                Q_W2: if (!i_status.mul_busy) begin
                    r_value <= i_mul;
                    r_done  <= 1'b1;
                    r_state <= IDLE;
                end
                default: r_state <= IDLE;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            B_ONE:   o_step = S_WRONE;
            B_DIV:   o_step = S_DIV;
            B_RDINV: o_step = S_RDINV;
            B_MINV:  o_step = S_MULINV;
            B_WINV:  o_step = i_status.mul_busy ? S_NONE : S_WRINV;
            B_MFAC:  o_step = S_MULFAC;
            B_WFAC:  o_step = i_status.mul_busy ? S_NONE : S_WRFAC;
            B_MFI:   o_step = S_MULFI;
            B_WFI:   o_step = i_status.mul_busy ? S_NONE : S_WRFI;
            Q_RD:    o_step = S_QRD;
            Q_M1:    o_step = S_QMUL1;
            Q_M2:    o_step = S_QMUL2;
            default: o_step = S_NONE;
        endcase
    end

    assign o_load  = (r_state == B_ONE);
    assign o_n     = r_n;
    assign o_k     = r_k;
    assign o_idx   = r_i[IW-1:0];
    assign o_busy  = (r_state != IDLE) || r_done;
    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_stat  = r_stat;
endmodule
`default_nettype wire

// ===== src/binomial_coefficient_mod_prime.sv =====
// Top level of the binomial coefficient modulo 998244353 block.
// Depends on bcmp_pkg, bcmp_ctrl and bcmp_datapath.
// A beat is taken when start is high and busy low; its single result appears
// for one cycle with o_done and cannot be stalled. A query passes through the
// table read and two modular products, each an issue step and a Barrett
// reduction, and the next beat can be taken only after its result. An init beat
// builds each table entry with a divider step, a read of the earlier inverse
// and three modular products. Queries before an init return status 2.
// The tables need no clearing after reset.
`default_nettype none
module binomial_coefficient_mod_prime
    import bcmp_pkg::*;
#(
    parameter int TABLE_SIZE = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_action,
    input  wire logic [12:0] i_top,
    input  wire logic [12:0] i_choose,
    output logic             o_done,
    output logic [29:0]      o_value,
    output logic [1:0]       o_status
);
    localparam int IW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;

    t_status       dp_status;
    logic [3:0]    step;
    logic          load;
    logic [IW-1:0] qn, qk, idx;
    logic [VW-1:0] mul;

    bcmp_ctrl #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start && !busy),
        .i_action(i_action), .i_n(i_top), .i_k(i_choose),
        .i_status(dp_status), .i_mul(mul), .o_step(step), .o_load(load),
        .o_n(qn), .o_k(qk), .o_idx(idx), .o_busy(busy), .o_done(o_done),
        .o_value(o_value), .o_stat(o_status)
    );

    bcmp_datapath #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_load(load),
        .i_n(qn), .i_k(qk), .i_idx(idx), .o_status(dp_status), .o_mul(mul)
    );
endmodule
`default_nettype wire

// ===== verif/binomial_coefficient_mod_prime_tb.sv =====
// Testbench for binomial_coefficient_mod_prime: directed table plus random beats,
// checked against typed row values or a table predictor built inside the bench.
// Depends on bcmp_pkg and the RTL of the block only.
`default_nettype none
module binomial_coefficient_mod_prime_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bcmp_pkg::*;

    localparam int TBL = 4096;
    localparam longint unsigned PMOD = 998244353;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam logic ACT_INIT = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct {
        logic [29:0] value;
        logic [1:0]  status;
    } t_binom;

    typedef struct {
        logic        act;
        int          n;
        int          k;
        bit          typed;
        logic [29:0] value;
        logic [1:0]  status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [12:0] i_top;
    logic [12:0] i_choose;
    logic        o_done;
    logic [29:0] o_value;
    logic [1:0]  o_status;

    binomial_coefficient_mod_prime #(.TABLE_SIZE(TBL)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_top(i_top), .i_choose(i_choose),
        .o_done(o_done), .o_value(o_value), .o_status(o_status)
    );

    longint unsigned fac_tbl[TBL];
    longint unsigned inv_tbl[TBL];
    longint unsigned finv_tbl[TBL];
    bit              built;
    t_binom          pending_binoms[$];
    int              mismatches;
    int              beats;
    int              results;
    int              inits;
    longint          cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned mul_p(longint unsigned a, longint unsigned b);
        return (a * b) % PMOD;
    endfunction

    function automatic void build_binom_tables();
        fac_tbl[0] = 1; fac_tbl[1] = 1;
        finv_tbl[0] = 1; finv_tbl[1] = 1;
        inv_tbl[0] = 0; inv_tbl[1] = 1;
        for (int i = 2; i < TBL; i++) begin
            fac_tbl[i] = mul_p(fac_tbl[i-1], i);
            inv_tbl[i] = PMOD - mul_p(inv_tbl[PMOD % i], PMOD / i);
            finv_tbl[i] = mul_p(finv_tbl[i-1], inv_tbl[i]);
        end
        built = 1'b1;
    endfunction

    function automatic t_binom predict_binom(logic act, logic [12:0] top, logic [12:0] ch);
        t_binom r;
        int n;
        int k;
        n = $signed(top);
        k = $signed(ch);
        r.value = '0;
        r.status = ST_OK;
        if (act == ACT_INIT) begin
            build_binom_tables();
        end else if (!built) begin
            r.status = ST_NOTRDY;
        end else if (n < k || n < 0 || k < 0) begin
            r.status = ST_OK;
        end else if (n >= TBL) begin
            r.status = ST_RANGE;
        end else begin
            r.value = 30'(mul_p(fac_tbl[n], mul_p(finv_tbl[k], finv_tbl[n-k])));
        end
        return r;
    endfunction

    task automatic send_beat(logic act, logic [12:0] top, logic [12:0] ch, bit typed,
                             logic [29:0] tv, logic [1:0] ts);
        t_binom r;
        start <= 1'b1;
        i_action <= act;
        i_top <= top;
        i_choose <= ch;
        do @(posedge i_clk); while (busy);
        r = predict_binom(act, top, ch);
        if (typed) begin
            r.value = tv;
            r.status = ts;
        end
        pending_binoms.push_back(r);
        beats++;
        if (act == ACT_INIT) inits++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results++;
            if (pending_binoms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d status=%0d", o_value, o_status);
            end else begin
                t_binom e;
                e = pending_binoms.pop_front();
                if (e.value !== o_value || e.status !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                                 e.value, e.status, o_value, o_status);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        int   n;
        int   k;
        int   sel;
        int   phase;
        int   idle_pct;
        logic act;

        cycles = 0;
        built = 1'b0;
        mismatches = 0;
        beats = 0;
        results = 0;
        inits = 0;
        start = 1'b0;
        i_action = 1'b0;
        i_top = '0;
        i_choose = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{ACT_QUERY, 5, 2, 1, 30'd0, ST_NOTRDY});
        rows.push_back('{ACT_QUERY, 4095, -4096, 1, 30'd0, ST_NOTRDY});
        rows.push_back('{ACT_INIT, -1, 4095, 1, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, 0, 0, 1, 30'd1, ST_OK});
        rows.push_back('{ACT_QUERY, 1, 1, 1, 30'd1, ST_OK});
        rows.push_back('{ACT_QUERY, 5, 2, 1, 30'd10, ST_OK});
        rows.push_back('{ACT_QUERY, TBL-1, TBL-1, 1, 30'd1, ST_OK});
        rows.push_back('{ACT_QUERY, TBL-1, 0, 1, 30'd1, ST_OK});
        rows.push_back('{ACT_QUERY, TBL-1, 1, 1, 30'(TBL-1), ST_OK});
        rows.push_back('{ACT_QUERY, 3, 4, 1, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, -1, -3, 1, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, 7, -1, 1, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, -4096, -4096, 1, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, TBL, 0, 0, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, 4095, 4095, 0, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, 4095, 0, 0, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, TBL-1, TBL/2, 0, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, 100, 37, 0, 30'd0, ST_OK});
        rows.push_back('{ACT_INIT, 4095, -1, 1, 30'd0, ST_OK});
        rows.push_back('{ACT_QUERY, TBL-2, 3, 0, 30'd0, ST_OK});
        foreach (rows[i])
            send_beat(rows[i].act, 13'(rows[i].n), 13'(rows[i].k), rows[i].typed,
                      rows[i].value, rows[i].status);

        for (int i = 0; i < 1300; i++) begin
            phase = (i / 100) % 3;
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 47 : 19;
            sel = $urandom_range(999);
            act = ACT_QUERY;
            if (sel < 5) begin
                act = ACT_INIT;
                n = $urandom;
                k = $urandom;
            end else if (sel < 700) begin
                n = ($urandom_range(3) == 0) ? $urandom_range(TBL-1) : $urandom_range(31);
                k = $urandom_range(n);
            end else if (sel < 800) begin
                n = $urandom_range(4095, TBL);
                k = $urandom_range(n);
            end else begin
                n = $urandom;
                k = $urandom;
            end
            send_beat(act, 13'(n), 13'(k), 1'b0, '0, ST_OK);
            if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (pending_binoms.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d beats (%0d table builds) and %0d results, table size %0d",
                 beats, inits, results, TBL);
        $display("queries spanned not-ready, negative, n<k, table-edge and valid cases");
        if (mismatches == 0 && pending_binoms.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_binoms.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== binomial_coefficient_mod_prime.f =====
src/bcmp_pkg.sv
src/bcmp_mulmod.sv
src/bcmp_divider.sv
src/bcmp_datapath.sv
src/bcmp_ctrl.sv
src/binomial_coefficient_mod_prime.sv
verif/binomial_coefficient_mod_prime_tb.sv
